// File: hw/rtl/rgrc_pkg.sv
// ----------------------------------------------------------------------------
// RTT gradient rate control package
// Shared types, codes and constants of the rate control core.
// ----------------------------------------------------------------------------
package rgrc_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_EWMA_WEIGHT  = 3'd0,
      CSR_DECREASE     = 3'd1,
      CSR_ADD_STEP     = 3'd2,
      CSR_LOW_THRESH   = 3'd3,
      CSR_HIGH_THRESH  = 3'd4,
      CSR_HAI_EVENTS   = 3'd5
   } csr_index_type;

   // Reset values of the configuration registers
   localparam logic [15:0] EWMA_WEIGHT_RESET = 16'd6554;
   localparam logic [15:0] DECREASE_RESET    = 16'd32768;
   localparam logic [15:0] ADD_STEP_RESET    = 16'd1500;
   localparam logic [15:0] LOW_THRESH_RESET  = 16'd50;
   localparam logic [15:0] HIGH_THRESH_RESET = 16'd500;
   localparam logic [3:0]  HAI_EVENTS_RESET  = 4'd5;

   localparam logic [15:0] MIN_RTT_RESET = 16'hFFFF;
   localparam logic [3:0]  EVENT_MAX     = 4'hF;
   localparam int          EWMA_SHIFT    = 16;

   // Commands on the input channel
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_OPEN   = 1'b1;

   // Action codes of a result
   typedef enum logic [2:0] {
      ACT_KEEP  = 3'd0,
      ACT_LOW   = 3'd1,
      ACT_HIGH  = 3'd2,
      ACT_ADD   = 3'd3,
      ACT_HAI   = 3'd4,
      ACT_GDEC  = 3'd5
   } action_type;

   // Decision made from a sample
   typedef enum logic [1:0] {
      PATH_LOW,
      PATH_HIGH,
      PATH_ADD,
      PATH_GRAD
   } path_type;

   typedef enum logic [1:0] {
      MUL_EWMA,
      MUL_HIGH,
      MUL_GRAD,
      MUL_SCALE
   } mul_sel_type;

   typedef enum logic {
      DIV_HIGH,
      DIV_GRAD
   } div_sel_type;

   typedef enum logic [2:0] {
      RES_KEEP,
      RES_LOW,
      RES_ADD,
      RES_HIGH,
      RES_GZERO,
      RES_GSCALE
   } res_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EWMA,
      ST_DECIDE,
      ST_HI_MUL,
      ST_HI_DIV,
      ST_GR_MUL,
      ST_GR_DIV,
      ST_GR_SCALE,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic        load_in;
      logic        mul_go;
      mul_sel_type mul_sel;
      logic        div_go;
      div_sel_type div_sel;
      logic        avg_we;
      logic        decide;
      logic        res_we;
      res_sel_type res_sel;
      logic        out_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic     skip;
      path_type path;
      logic     mul_busy;
      logic     div_busy;
      logic     ratio_big;
      logic     out_free;
   } dp_status_type;

endpackage

// File: hw/rtl/rgrc_channels.sv
// ----------------------------------------------------------------------------
// RTT gradient rate control channels
// Valid/ready channel interfaces for samples, results and register writes.
// ----------------------------------------------------------------------------
interface rgrc_req_if #(parameter int WINDOW_BITS = 32);
   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [15:0]            rtt_ms;
   logic [WINDOW_BITS-1:0] current_window;

   modport source (output valid, output command, output rtt_ms,
                   output current_window, input ready);
   modport sink (input valid, input command, input rtt_ms,
                 input current_window, output ready);
endinterface

interface rgrc_rsp_if #(parameter int WINDOW_BITS = 32);
   logic                   valid;
   logic                   ready;
   logic [WINDOW_BITS-1:0] new_window;
   logic [2:0]             action;

   modport source (output valid, output new_window, output action, input ready);
   modport sink (input valid, input new_window, input action, output ready);
endinterface

interface rgrc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/rtt_gradient_rate_control_core.sv
// ----------------------------------------------------------------------------
// RTT gradient rate control core
// Window controller driven by RTT samples, with a gradient based decrease.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on req_ch carries a command, an RTT sample in milliseconds and
// the current window; each one returns exactly one beat on rsp_ch with the
// new window and the action taken. Registers are written through csr_ch,
// which is always ready; write them only while the core is idle.
// An open-state command or a zero RTT skips the arithmetic. A sample
// first runs the EWMA update on the shift-add multiplier over the
// 16 weight bits; a low or additive step then writes its result directly.
// The high threshold decrease adds a multiply over up to 32 bits and a
// divide over max(WINDOW_BITS+32, FRAC_BITS+42) dividend bits; the
// gradient decrease adds a short multiply, one such divide and, unless the
// ratio is too large, a second short multiply. The shared multiplier and
// the one-bit-per-cycle divider set the pace. One item is worked on at a
// time. Reset restores the register defaults and clears the RTT state.
// When rsp_ch stalls, the finished result waits in the output register and
// the core takes the next sample; it holds its following result until the
// output register is free.
// ----------------------------------------------------------------------------
module rtt_gradient_rate_control_core #(
   parameter int WINDOW_BITS = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   rgrc_req_if.sink   req_ch,
   rgrc_rsp_if.source rsp_ch,
   rgrc_csr_if.sink   csr_ch
);

   rgrc_pkg::ctrl_cmd_type  cmd;
   rgrc_pkg::dp_status_type status;

   assign csr_ch.ready = 1'b1;

   rgrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rgrc_datapath #(
      .WINDOW_BITS (WINDOW_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_command        (req_ch.command),
      .req_rtt_ms         (req_ch.rtt_ms),
      .req_current_window (req_ch.current_window[WINDOW_BITS-1:0]),
      .csr_valid          (csr_ch.valid),
      .csr_index          (csr_ch.index),
      .csr_data           (csr_ch.data),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_new_window     (rsp_ch.new_window),
      .rsp_action         (rsp_ch.action),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

// File: hw/rtl/rgrc_mul.sv
// ----------------------------------------------------------------------------
// RTT gradient rate control multiplier
// Shift-add multiplier, one multiplier bit per cycle, stops early when the
// remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module rgrc_mul #(
   parameter int PW = 64,
   parameter int BW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  logic [PW-1:0] a,
   input  logic [BW-1:0] b,
   output logic          busy,
   output logic [PW-1:0] product
);

   logic          busy_ff, busy_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [PW-1:0] a_ff, a_in;
   logic [BW-1:0] b_ff, b_in;

   // One partial product is added per cycle
   always_comb begin
      busy_in = busy_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (go) begin
         busy_in = 1'b1;
         acc_in  = '0;
         a_in    = a;
         b_in    = b;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[PW-2:0], 1'b0};
            b_in = {1'b0, b_ff[BW-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign busy    = busy_ff;
   assign product = acc_ff;

endmodule

// File: hw/rtl/rgrc_div.sv
// ----------------------------------------------------------------------------
// RTT gradient rate control divider
// Restoring divider, one quotient bit per cycle over the dividend width.
// ----------------------------------------------------------------------------
module rgrc_div #(
   parameter int DW = 64,
   parameter int VW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [VW:0]   rem_sh;
   logic [VW:0]   rem_sub;

   assign rem_sh  = {rem_ff, quo_ff[DW-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   // Shift in one dividend bit and try a subtraction each cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sub[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// File: hw/rtl/rgrc_ctrl.sv
// ----------------------------------------------------------------------------
// RTT gradient rate control controller
// Sequences one sample through the EWMA update, the decision and the
// multiply and divide steps of the chosen window update.
// ----------------------------------------------------------------------------
module rgrc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rgrc_pkg::dp_status_type status,
   output rgrc_pkg::ctrl_cmd_type  cmd
);

   rgrc_pkg::state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rgrc_pkg::ST_IDLE: begin
            if (req_valid) state_in = rgrc_pkg::ST_CHECK;
         end
         rgrc_pkg::ST_CHECK: begin
            state_in = status.skip ? rgrc_pkg::ST_DONE : rgrc_pkg::ST_EWMA;
         end
         rgrc_pkg::ST_EWMA: begin
            if (!status.mul_busy) state_in = rgrc_pkg::ST_DECIDE;
         end
         rgrc_pkg::ST_DECIDE: begin
            unique case (status.path)
               rgrc_pkg::PATH_HIGH: state_in = rgrc_pkg::ST_HI_MUL;
               rgrc_pkg::PATH_GRAD: state_in = rgrc_pkg::ST_GR_MUL;
               default:             state_in = rgrc_pkg::ST_DONE;
            endcase
         end
         rgrc_pkg::ST_HI_MUL: begin
            if (!status.mul_busy) state_in = rgrc_pkg::ST_HI_DIV;
         end
         rgrc_pkg::ST_HI_DIV: begin
            if (!status.div_busy) state_in = rgrc_pkg::ST_DONE;
         end
         rgrc_pkg::ST_GR_MUL: begin
            if (!status.mul_busy) state_in = rgrc_pkg::ST_GR_DIV;
         end
         rgrc_pkg::ST_GR_DIV: begin
            if (!status.div_busy) begin
               state_in = status.ratio_big ? rgrc_pkg::ST_DONE : rgrc_pkg::ST_GR_SCALE;
            end
         end
         rgrc_pkg::ST_GR_SCALE: begin
            if (!status.mul_busy) state_in = rgrc_pkg::ST_DONE;
         end
         rgrc_pkg::ST_DONE: begin
            if (status.out_free) state_in = rgrc_pkg::ST_IDLE;
         end
         default: state_in = rgrc_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         rgrc_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         rgrc_pkg::ST_CHECK: begin
            if (status.skip) begin
               cmd.res_we  = 1'b1;
               cmd.res_sel = rgrc_pkg::RES_KEEP;
            end else begin
               cmd.mul_go  = 1'b1;
               cmd.mul_sel = rgrc_pkg::MUL_EWMA;
            end
         end
         rgrc_pkg::ST_EWMA: begin
            cmd.avg_we = !status.mul_busy;
         end
         rgrc_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            unique case (status.path)
               rgrc_pkg::PATH_LOW: begin
                  cmd.res_we  = 1'b1;
                  cmd.res_sel = rgrc_pkg::RES_LOW;
               end
               rgrc_pkg::PATH_ADD: begin
                  cmd.res_we  = 1'b1;
                  cmd.res_sel = rgrc_pkg::RES_ADD;
               end
               rgrc_pkg::PATH_HIGH: begin
                  cmd.mul_go  = 1'b1;
                  cmd.mul_sel = rgrc_pkg::MUL_HIGH;
               end
               default: begin
                  cmd.mul_go  = 1'b1;
                  cmd.mul_sel = rgrc_pkg::MUL_GRAD;
               end
            endcase
         end
         rgrc_pkg::ST_HI_MUL: begin
            cmd.div_go  = !status.mul_busy;
            cmd.div_sel = rgrc_pkg::DIV_HIGH;
         end
         rgrc_pkg::ST_HI_DIV: begin
            cmd.res_we  = !status.div_busy;
            cmd.res_sel = rgrc_pkg::RES_HIGH;
         end
         rgrc_pkg::ST_GR_MUL: begin
            cmd.div_go  = !status.mul_busy;
            cmd.div_sel = rgrc_pkg::DIV_GRAD;
         end
         rgrc_pkg::ST_GR_DIV: begin
            if (!status.div_busy) begin
               if (status.ratio_big) begin
                  cmd.res_we  = 1'b1;
                  cmd.res_sel = rgrc_pkg::RES_GZERO;
               end else begin
                  cmd.mul_go  = 1'b1;
                  cmd.mul_sel = rgrc_pkg::MUL_SCALE;
               end
            end
         end
         rgrc_pkg::ST_GR_SCALE: begin
            cmd.res_we  = !status.mul_busy;
            cmd.res_sel = rgrc_pkg::RES_GSCALE;
         end
         rgrc_pkg::ST_DONE: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rgrc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/rgrc_datapath.sv
// ----------------------------------------------------------------------------
// RTT gradient rate control datapath
// Holds the configuration and RTT state, the shared multiplier and divider,
// the result selection and the output register.
// ----------------------------------------------------------------------------
module rgrc_datapath #(
   parameter int WINDOW_BITS = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_command,
   input  logic [15:0]             req_rtt_ms,
   input  logic [WINDOW_BITS-1:0]  req_current_window,
   input  logic                    csr_valid,
   input  logic [2:0]              csr_index,
   input  logic [15:0]             csr_data,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [WINDOW_BITS-1:0]  rsp_new_window,
   output logic [2:0]              rsp_action,
   input  rgrc_pkg::ctrl_cmd_type   cmd,
   output rgrc_pkg::dp_status_type  status
);

   localparam int W     = WINDOW_BITS;
   localparam int AVG_W = FRAC_BITS + 24;
   localparam int EW    = AVG_W + 2;
   localparam int PW    = (W + 32 > FRAC_BITS + 42) ? W + 32 : FRAC_BITS + 42;
   localparam int VW    = (FRAC_BITS + 16 > 32) ? FRAC_BITS + 16 : 32;
   localparam int BW    = 32;
   localparam int SW    = W + 4;

   // Configuration registers
   logic [15:0] weight_ff, beta_ff, step_ff, low_ff, high_ff;
   logic [3:0]  hai_ff;

   // RTT state
   logic [15:0]             min_ff, prev_ff;
   logic                    prev_valid_ff;
   logic signed [AVG_W-1:0] avg_ff;
   logic [3:0]              ec_ff, ec_inc;

   // Item held while it is worked on
   logic                    cmd_ff;
   logic [15:0]             rtt_ff;
   logic [W-1:0]            cw_ff;
   logic signed [EW-1:0]    e_ff;
   logic signed [EW-1:0]    e_calc;
   logic signed [16:0]      diff;

   // Pending result and output register
   logic [W-1:0]            nw_ff;
   rgrc_pkg::action_type    act_ff;
   logic                    rsp_valid_ff;
   logic [W-1:0]            rsp_nw_ff;
   rgrc_pkg::action_type    rsp_act_ff;

   logic                    mul_busy, div_busy;
   logic [PW-1:0]           mul_a, product, quotient;
   logic [BW-1:0]           mul_b;
   logic [VW-1:0]           divisor;
   logic [31:0]             hi_cut, hi_num;
   logic [16:0]             scale_b;
   logic [18:0]             inc1, inc5;
   logic                    hai;
   logic [SW-1:0]           sum_low, sum_add;
   logic [W-1:0]            sat_low, sat_add;
   rgrc_pkg::path_type      path;

   // Difference to the previous sample in Q.FRAC, less the running average
   assign diff   = prev_valid_ff ? $signed({1'b0, req_rtt_ms}) - $signed({1'b0, prev_ff})
                                 : 17'sd0;
   assign e_calc = ($signed(EW'(diff)) <<< FRAC_BITS) - $signed(EW'(avg_ff));

   // Decision for a sample, taken after the average is updated
   always_comb begin
      if (rtt_ff < low_ff) begin
         path = rgrc_pkg::PATH_LOW;
      end else if (rtt_ff > high_ff) begin
         path = rgrc_pkg::PATH_HIGH;
      end else if (avg_ff <= 0) begin
         path = rgrc_pkg::PATH_ADD;
      end else begin
         path = rgrc_pkg::PATH_GRAD;
      end
   end

   // High threshold factor numerator, 65536*rtt - beta*(rtt-high)
   assign hi_cut = beta_ff * (rtt_ff - high_ff);
   assign hi_num = {rtt_ff, 16'h0000} - hi_cut;
   assign scale_b = 17'h10000 - {1'b0, quotient[15:0]};

   // Multiplier operand selection
   always_comb begin
      unique case (cmd.mul_sel)
         rgrc_pkg::MUL_EWMA: begin
            mul_a = PW'(e_ff);
            mul_b = BW'(weight_ff);
         end
         rgrc_pkg::MUL_HIGH: begin
            mul_a = PW'(cw_ff);
            mul_b = hi_num;
         end
         rgrc_pkg::MUL_GRAD: begin
            mul_a = PW'(unsigned'(avg_ff));
            mul_b = BW'(beta_ff);
         end
         default: begin
            mul_a = PW'(cw_ff);
            mul_b = BW'(scale_b);
         end
      endcase
   end

   // Sign extension of the difference term into the product width
   rgrc_mul #(.PW(PW), .BW(BW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (cmd.mul_go),
      .a       ((cmd.mul_sel == rgrc_pkg::MUL_EWMA) ? {{(PW-EW){e_ff[EW-1]}}, e_ff} : mul_a),
      .b       (mul_b),
      .busy    (mul_busy),
      .product (product)
   );

   assign divisor = (cmd.div_sel == rgrc_pkg::DIV_HIGH) ? VW'({rtt_ff, 16'h0000})
                                                       : VW'({min_ff, {FRAC_BITS{1'b0}}});

   rgrc_div #(.DW(PW), .VW(VW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (product),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Additive steps with saturation at the window maximum
   assign ec_inc  = (ec_ff == rgrc_pkg::EVENT_MAX) ? ec_ff : ec_ff + 4'd1;
   assign hai     = (ec_inc >= hai_ff);
   assign inc1    = 19'(step_ff);
   assign inc5    = {1'b0, step_ff, 2'b00} + inc1;
   assign sum_low = SW'(cw_ff) + SW'(inc1);
   assign sum_add = SW'(cw_ff) + SW'(hai ? inc5 : inc1);
   assign sat_low = (sum_low[SW-1:W] != '0) ? {W{1'b1}} : sum_low[W-1:0];
   assign sat_add = (sum_add[SW-1:W] != '0) ? {W{1'b1}} : sum_add[W-1:0];

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= rgrc_pkg::EWMA_WEIGHT_RESET;
         beta_ff   <= rgrc_pkg::DECREASE_RESET;
         step_ff   <= rgrc_pkg::ADD_STEP_RESET;
         low_ff    <= rgrc_pkg::LOW_THRESH_RESET;
         high_ff   <= rgrc_pkg::HIGH_THRESH_RESET;
         hai_ff    <= rgrc_pkg::HAI_EVENTS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            rgrc_pkg::CSR_EWMA_WEIGHT: weight_ff <= csr_data;
            rgrc_pkg::CSR_DECREASE:    beta_ff   <= csr_data;
            rgrc_pkg::CSR_ADD_STEP:    step_ff   <= csr_data;
            rgrc_pkg::CSR_LOW_THRESH:  low_ff    <= csr_data;
            rgrc_pkg::CSR_HIGH_THRESH: high_ff   <= csr_data;
            rgrc_pkg::CSR_HAI_EVENTS:  hai_ff    <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // RTT state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff        <= rgrc_pkg::MIN_RTT_RESET;
         prev_ff       <= '0;
         prev_valid_ff <= 1'b0;
         avg_ff        <= '0;
         ec_ff         <= '0;
      end else begin
         if (cmd.load_in) begin
            if (req_command != rgrc_pkg::CMD_SAMPLE) begin
               min_ff <= rgrc_pkg::MIN_RTT_RESET;
            end else if (req_rtt_ms != '0) begin
               if (req_rtt_ms < min_ff) min_ff <= req_rtt_ms;
               prev_ff       <= req_rtt_ms;
               prev_valid_ff <= 1'b1;
            end
         end
         if (cmd.avg_we) begin
            avg_ff <= avg_ff + $signed(product[AVG_W+rgrc_pkg::EWMA_SHIFT-1:rgrc_pkg::EWMA_SHIFT]);
         end
         if (cmd.decide) begin
            ec_ff <= (path == rgrc_pkg::PATH_ADD) ? ec_inc : 4'd0;
         end
      end
   end

   // Item and pending result registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         cmd_ff <= req_command;
         rtt_ff <= req_rtt_ms;
         cw_ff  <= req_current_window;
         e_ff   <= e_calc;
      end
      if (cmd.res_we) begin
         unique case (cmd.res_sel)
            rgrc_pkg::RES_KEEP: begin
               nw_ff  <= cw_ff;
               act_ff <= rgrc_pkg::ACT_KEEP;
            end
            rgrc_pkg::RES_LOW: begin
               nw_ff  <= sat_low;
               act_ff <= rgrc_pkg::ACT_LOW;
            end
            rgrc_pkg::RES_ADD: begin
               nw_ff  <= sat_add;
               act_ff <= hai ? rgrc_pkg::ACT_HAI : rgrc_pkg::ACT_ADD;
            end
            rgrc_pkg::RES_HIGH: begin
               nw_ff  <= quotient[W-1:0];
               act_ff <= rgrc_pkg::ACT_HIGH;
            end
            rgrc_pkg::RES_GZERO: begin
               nw_ff  <= '0;
               act_ff <= rgrc_pkg::ACT_GDEC;
            end
            default: begin
               nw_ff  <= product[W+15:16];
               act_ff <= rgrc_pkg::ACT_GDEC;
            end
         endcase
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_nw_ff  <= nw_ff;
         rsp_act_ff <= act_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_window = rsp_nw_ff;
   assign rsp_action     = rsp_act_ff;

   assign status.skip      = (cmd_ff != rgrc_pkg::CMD_SAMPLE) || (rtt_ff == '0);
   assign status.path      = path;
   assign status.mul_busy  = mul_busy;
   assign status.div_busy  = div_busy;
   assign status.ratio_big = (quotient[PW-1:16] != '0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // The multiplier and the divider are never started on top of each other
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_busy && div_busy))
      else $error("multiplier and divider busy together");

   // The minimum RTT used as a divisor is never zero
   a_min_nonzero: assert property (@(posedge clock) disable iff (reset)
      min_ff != '0)
      else $error("minimum RTT is zero");

   // A result is only loaded into a free output register
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote a pending output");

   // A loaded result is presented on the next cycle
   a_out_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not shown");

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// RTT gradient rate control testbench
// Drives RTT samples, open-state commands and register writes into the core
// and checks every window update against a cycle-free predictor of the core.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic [31:0]          win;
      rgrc_pkg::action_type act;
   } window_update_type;

   // Window predictor and store of expected updates
   class window_scoreboard;
      int unsigned weight, beta, step, low_thr, high_thr, hai_min;
      int unsigned min_rtt, prev_rtt, events;
      bit          prev_valid;
      longint      avg_diff;
      window_update_type updates_due[$];
      int          errors;

      function new();
         weight = rgrc_pkg::EWMA_WEIGHT_RESET;
         beta = rgrc_pkg::DECREASE_RESET;
         step = rgrc_pkg::ADD_STEP_RESET;
         low_thr = rgrc_pkg::LOW_THRESH_RESET;
         high_thr = rgrc_pkg::HIGH_THRESH_RESET;
         hai_min = rgrc_pkg::HAI_EVENTS_RESET;
         min_rtt = rgrc_pkg::MIN_RTT_RESET;
         prev_rtt = 0;
         prev_valid = 0;
         avg_diff = 0;
         events = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] value);
         case (rgrc_pkg::csr_index_type'(idx))
            rgrc_pkg::CSR_EWMA_WEIGHT: weight = value;
            rgrc_pkg::CSR_DECREASE:    beta = value;
            rgrc_pkg::CSR_ADD_STEP:    step = value;
            rgrc_pkg::CSR_LOW_THRESH:  low_thr = value;
            rgrc_pkg::CSR_HIGH_THRESH: high_thr = value;
            rgrc_pkg::CSR_HAI_EVENTS:  hai_min = value[3:0];
            default: ;
         endcase
      endfunction

      function longint unsigned add_sat(logic [31:0] cw, longint unsigned inc);
         longint unsigned sum;
         sum = longint'(cw) + inc;
         return (sum > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : sum;
      endfunction

      // Notes an accepted input beat and works out its window update.
      function void note_input(logic cmd, logic [15:0] rtt, logic [31:0] cw);
         longint diff, acc;
         longint unsigned den, num, r, n;
         logic [127:0] prod;
         window_update_type e;
         e.win = cw;
         e.act = rgrc_pkg::ACT_KEEP;
         if (cmd != rgrc_pkg::CMD_SAMPLE) begin
            min_rtt = rgrc_pkg::MIN_RTT_RESET;
         end else if (rtt != 0) begin
            diff = prev_valid ? longint'(rtt) - longint'(prev_rtt) : 0;
            if (rtt < min_rtt) min_rtt = rtt;
            prev_rtt = rtt;
            prev_valid = 1;
            acc = longint'(65536 - weight) * avg_diff + longint'(weight) * (diff <<< 16);
            avg_diff = acc >>> 16;
            if (rtt < low_thr) begin
               events = 0;
               e.win = 32'(add_sat(cw, step));
               e.act = rgrc_pkg::ACT_LOW;
            end else if (rtt > high_thr) begin
               den = 64'(rtt) * 65536;
               num = den - 64'(beta) * (rtt - high_thr);
               events = 0;
               prod = (128'(cw) * num) / den;
               e.win = prod[31:0];
               e.act = rgrc_pkg::ACT_HIGH;
            end else if (avg_diff <= 0) begin
               n = 1;
               if (events < rgrc_pkg::EVENT_MAX) events++;
               e.act = rgrc_pkg::ACT_ADD;
               if (events >= hai_min) begin
                  n = 5;
                  e.act = rgrc_pkg::ACT_HAI;
               end
               e.win = 32'(add_sat(cw, n * step));
            end else begin
               den = 64'(min_rtt) << 16;
               r = (64'(beta) * 64'(avg_diff)) / den;
               events = 0;
               if (r >= 65536) e.win = '0;
               else begin
                  prod = (128'(cw) * (65536 - r)) >> 16;
                  e.win = prod[31:0];
               end
               e.act = rgrc_pkg::ACT_GDEC;
            end
         end
         updates_due.push_back(e);
      endfunction

      // Checks a result beat against the oldest expected update.
      function void check_result(logic [31:0] win, logic [2:0] act);
         window_update_type e;
         if (updates_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected result %h action %0d", win, act);
            return;
         end
         e = updates_due.pop_front();
         if (win !== e.win || act !== e.act) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: window exp %h got %h, action exp %0d got %0d",
                        e.win, win, e.act, act);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   window_scoreboard sb;
   bit   long_hold;
   int   idle_cycles;
   logic [15:0] last_rtt;

   rgrc_req_if #(.WINDOW_BITS(32)) req_ch ();
   rgrc_rsp_if #(.WINDOW_BITS(32)) rsp_ch ();
   rgrc_csr_if csr_ch ();

   rtt_gradient_rate_control_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Gap lengths: mostly short, a few long.
   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   // Monitor: note input beats, check result beats, log register writes.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_input(req_ch.command, req_ch.rtt_ms, req_ch.current_window);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.new_window, rsp_ch.action);
         if (csr_ch.valid && csr_ch.ready)
            sb.write_reg(csr_ch.index, csr_ch.data);
      end
   end

   // Watchdog on cycles with no beat at all.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 3000) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Result receiver: random stalls, plus one long hold-off on request.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ch.ready = 1'b0;
            repeat (400) @(negedge clock);
            long_hold = 0;
         end else if ($urandom_range(3) == 0) begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ch.ready = 1'b0;
               repeat (stall - 1) @(negedge clock);
            end else
               rsp_ch.ready = 1'b1;
         end else
            rsp_ch.ready = 1'b1;
      end
   end

   task automatic send_item(logic cmd, logic [15:0] rtt, logic [31:0] cw);
      int gap;
      req_ch.valid = 1'b1;
      req_ch.command = cmd;
      req_ch.rtt_ms = rtt;
      req_ch.current_window = cw;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic sample(logic [15:0] rtt, logic [31:0] cw);
      send_item(rgrc_pkg::CMD_SAMPLE, rtt, cw);
   endtask

   // Waits until the core is idle, then writes one register.
   task automatic write_reg(rgrc_pkg::csr_index_type idx, logic [15:0] value);
      req_ch.valid = 1'b0;
      while (sb.updates_due.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data = value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic set_regs(logic [15:0] w, logic [15:0] b, logic [15:0] s,
                           logic [15:0] lo, logic [15:0] hi, logic [3:0] h);
      write_reg(rgrc_pkg::CSR_EWMA_WEIGHT, w);
      write_reg(rgrc_pkg::CSR_DECREASE, b);
      write_reg(rgrc_pkg::CSR_ADD_STEP, s);
      write_reg(rgrc_pkg::CSR_LOW_THRESH, lo);
      write_reg(rgrc_pkg::CSR_HIGH_THRESH, hi);
      write_reg(rgrc_pkg::CSR_HAI_EVENTS, {12'd0, h});
   endtask

   function automatic logic [31:0] pick_window();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return $urandom_range(100000);
         default: return $urandom;
      endcase
   endfunction

   // One random item; mostly a drifting RTT between the thresholds.
   task automatic random_item();
      int p, lo, hi, v;
      lo = sb.low_thr;
      hi = sb.high_thr;
      p = $urandom_range(99);
      if (p < 4) begin
         send_item(rgrc_pkg::CMD_OPEN, 16'($urandom), pick_window());
         return;
      end
      if (p < 8) v = 0;
      else if (p < 18) v = (lo > 1) ? $urandom_range(lo - 1, 1) : $urandom_range(65535, 1);
      else if (p < 30) v = (hi < 65535) ? $urandom_range(65535, hi + 1) : 65535;
      else if (p < 38) v = $urandom;
      else begin
         v = int'(last_rtt) + $urandom_range(12) - 7;
         if (v < lo || v > hi || v <= 0)
            v = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(65535, 1);
      end
      v = v & 16'hFFFF;
      if (v != 0) last_rtt = 16'(v);
      sample(16'(v), pick_window());
   endtask

   initial begin
      sb = new();
      long_hold = 0;
      last_rtt = 100;
      req_ch.valid = 1'b0;
      req_ch.command = rgrc_pkg::CMD_SAMPLE;
      req_ch.rtt_ms = '0;
      req_ch.current_window = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = rgrc_pkg::CSR_EWMA_WEIGHT;
      csr_ch.data = '0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset settings.
      sample(16'd0, 32'd1000);
      send_item(rgrc_pkg::CMD_OPEN, 16'hFFFF, 32'hFFFF_FFFF);
      sample(16'd10, 32'hFFFF_FFF0);
      sample(16'd65535, 32'hFFFF_FFFF);
      sample(16'd600, 32'd0);
      sample(16'd500, 32'd40000);
      sample(16'd400, 32'd40000);
      sample(16'd300, 32'd40000);
      sample(16'd300, 32'd40000);
      sample(16'd200, 32'd40000);
      sample(16'd100, 32'd40000);
      sample(16'd50, 32'hFFFF_FFFF);
      sample(16'd400, 32'hFFFF_FFFF);
      sample(16'd480, 32'd123456789);
      send_item(rgrc_pkg::CMD_OPEN, 16'd0, 32'd5);
      sample(16'd490, 32'd123456789);
      sample(16'd49, 32'd0);

      // Extreme settings: no smoothing, full decrease, large steps.
      set_regs(16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd1, 4'd1);
      sample(16'd1, 32'hFFFF_FFFF);
      sample(16'd65535, 32'hAAAA_5555);
      sample(16'd1, 32'h5555_AAAA);
      sample(16'd2, 32'hFFFF_FFFF);

      // Random phases over several settings, extremes among them.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_regs(rgrc_pkg::EWMA_WEIGHT_RESET, rgrc_pkg::DECREASE_RESET,
                        rgrc_pkg::ADD_STEP_RESET, rgrc_pkg::LOW_THRESH_RESET,
                        rgrc_pkg::HIGH_THRESH_RESET, rgrc_pkg::HAI_EVENTS_RESET);
            1: set_regs(16'd0, 16'd0, 16'd0, 16'd65535, 16'd65535, 4'd15);
            2: set_regs(16'd65535, 16'd65535, 16'd65535, 16'd20, 16'd65535, 4'd2);
            default: set_regs(16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom_range(200)), 16'($urandom_range(2000, 200)),
                              4'($urandom_range(15, 1)));
         endcase
         last_rtt = 16'((sb.low_thr + sb.high_thr) / 2);
         if (last_rtt == 0) last_rtt = 1;
         for (int k = 0; k < 72; k++) begin
            if (ph == 0 && k == 10) long_hold = 1;
            random_item();
         end
      end

      req_ch.valid = 1'b0;
      while (sb.updates_due.size() != 0) @(negedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/rgrc_pkg.sv
hw/rtl/rgrc_channels.sv
hw/rtl/rgrc_mul.sv
hw/rtl/rgrc_div.sv
hw/rtl/rgrc_ctrl.sv
hw/rtl/rgrc_datapath.sv
hw/rtl/rtt_gradient_rate_control_core.sv
verif/testbench.sv
